/* rtl/pidc_pkg.sv */
// pidc_pkg: widths, register indexes, reset values and saturation helpers
// for the clamped PID controller. No dependencies.
package pidc_pkg;

	localparam int DATA_W  = 32;
	localparam int ACC_W   = 48;
	localparam int CFG_W   = 32;
	localparam int STEP_W  = 17;
	localparam int SCALE_W = 31;
	localparam int DRIVE_W = 24;
	localparam int IDX_W   = 3;
	localparam int FRAC_W  = 16;
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int SUM_W   = PROD_W;

	localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_STEP_TIME   = 3'd3;
	localparam logic [IDX_W-1:0] REG_DERIV_SCALE = 3'd4;

	localparam logic signed [DATA_W-1:0] PROP_GAIN_RST  = 32'sd13107;
	localparam logic signed [DATA_W-1:0] INTEG_GAIN_RST = 32'sd1311;
	localparam logic signed [DATA_W-1:0] DERIV_GAIN_RST = 32'sd7864;
	localparam logic [STEP_W-1:0]        STEP_TIME_RST  = 17'd1049;
	localparam logic [SCALE_W-1:0]       DERIV_SCALE_RST = 31'd4096;

	localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT = 24'sd6553600;
	localparam logic signed [SUM_W-1:0]   SUM_LIM_HI  = 66'sd6553600;
	localparam logic signed [SUM_W-1:0]   SUM_LIM_LO  = -66'sd6553600;

	// saturate a two-bit-wider value into the accumulator width
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
		logic signed [ACC_W-1:0] r;
		begin
			if (v[ACC_W+1:ACC_W-1] == 3'b000 || v[ACC_W+1:ACC_W-1] == 3'b111) begin
				r = v[ACC_W-1:0];
			end else if (v[ACC_W+1]) begin
				r = {1'b1, {(ACC_W-1){1'b0}}};
			end else begin
				r = {1'b0, {(ACC_W-1){1'b1}}};
			end
			return r;
		end
	endfunction

	// saturate a one-bit-wider difference into the data width
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DATA_W:0] v);
		logic signed [DATA_W-1:0] r;
		begin
			if (v[DATA_W] == v[DATA_W-1]) begin
				r = v[DATA_W-1:0];
			end else if (v[DATA_W]) begin
				r = {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				r = {1'b0, {(DATA_W-1){1'b1}}};
			end
			return r;
		end
	endfunction

endpackage

/* rtl/pid_controller_clamped_unit.sv */
// Clamped PID controller, one result word per input word, Q16.16 fixed point
// (drive is Q8.16). An accepted word first forms the error and its difference,
// then seven products go through a single registered 33x33 multiplier (the
// 48-bit integral and derivative are each split into a high and a low half),
// then the last product is folded into the sum and the sum is clamped to +-100
// into the output register. in_ready is low while a word is in flight, so the
// unit takes no new word before the last one is through. A result word still
// waiting at the output holds the clamp step until it is taken. The integral
// and the previous error reset to 0.
// Depends on pidc_pkg and pidc_mul.
module pid_controller_clamped_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pidc_pkg::IDX_W-1:0]           cfg_index,
	input  logic [pidc_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [pidc_pkg::DATA_W-1:0]   setpoint,
	input  logic signed [pidc_pkg::DATA_W-1:0]   measured,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pidc_pkg::DRIVE_W-1:0]  drive,
	output logic                                 clamped
);
	import pidc_pkg::*;

	localparam logic [3:0] ST_ERR  = 4'd0;
	localparam logic [3:0] ST_INC  = 4'd1;
	localparam logic [3:0] ST_DER  = 4'd2;
	localparam logic [3:0] ST_PROP = 4'd3;
	localparam logic [3:0] ST_IHI  = 4'd4;
	localparam logic [3:0] ST_ILO  = 4'd5;
	localparam logic [3:0] ST_DHI  = 4'd6;
	localparam logic [3:0] ST_DLO  = 4'd7;
	localparam logic [3:0] ST_ACC  = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic signed [DATA_W-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [STEP_W-1:0]         step_time_q;
	logic [SCALE_W-1:0]        deriv_scale_q;

	logic                      busy_q;
	logic [3:0]                step_q;
	logic signed [DATA_W-1:0]  sp_q, ms_q;
	logic signed [DATA_W-1:0]  err_q, last_err_q;
	logic signed [DATA_W:0]    diff_q;
	logic signed [ACC_W-1:0]   integ_q, deriv_q;
	logic signed [SUM_W-1:0]   acc_q;
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic                      clamped_q;

	logic signed [DATA_W:0]    raw_diff;
	logic signed [DATA_W-1:0]  err_sat;
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_sh;
	logic                      out_load;

	assign in_ready  = !busy_q;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clamped   = clamped_q;

	assign raw_diff = {sp_q[DATA_W-1], sp_q} - {ms_q[DATA_W-1], ms_q};
	assign err_sat  = sat_data(raw_diff);
	assign prod_sh  = prod >>> FRAC_W;
	assign out_load = busy_q && step_q == ST_OUT && (!out_valid_q || out_ready);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			ST_INC: begin
				mul_a = MUL_W'(err_q);
				mul_b = MUL_W'({1'b0, step_time_q});
			end
			ST_DER: begin
				mul_a = MUL_W'(diff_q);
				mul_b = MUL_W'({1'b0, deriv_scale_q});
			end
			ST_PROP: begin
				mul_a = MUL_W'(prop_gain_q);
				mul_b = MUL_W'(err_q);
			end
			ST_IHI: begin
				mul_a = MUL_W'(integ_gain_q);
				mul_b = MUL_W'($signed(integ_q[ACC_W-1:FRAC_W]));
			end
			ST_ILO: begin
				mul_a = MUL_W'(integ_gain_q);
				mul_b = MUL_W'({1'b0, integ_q[FRAC_W-1:0]});
			end
			ST_DHI: begin
				mul_a = MUL_W'(deriv_gain_q);
				mul_b = MUL_W'($signed(deriv_q[ACC_W-1:FRAC_W]));
			end
			ST_DLO: begin
				mul_a = MUL_W'(deriv_gain_q);
				mul_b = MUL_W'({1'b0, deriv_q[FRAC_W-1:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pidc_mul u_mul (
		.clk  (clk),
		.en   (busy_q),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= PROP_GAIN_RST;
			integ_gain_q  <= INTEG_GAIN_RST;
			deriv_gain_q  <= DERIV_GAIN_RST;
			step_time_q   <= STEP_TIME_RST;
			deriv_scale_q <= DERIV_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data[DATA_W-1:0];
				REG_INTEG_GAIN:  integ_gain_q  <= cfg_data[DATA_W-1:0];
				REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data[DATA_W-1:0];
				REG_STEP_TIME:   step_time_q   <= cfg_data[STEP_W-1:0];
				REG_DERIV_SCALE: deriv_scale_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= ST_ERR;
			last_err_q  <= '0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				if (in_valid) begin
					busy_q <= 1'b1;
					step_q <= ST_ERR;
				end
			end else begin
				case (step_q)
					ST_ERR: begin
						last_err_q <= err_sat;
					end
					ST_DER: begin
						integ_q <= sat_acc({{2{integ_q[ACC_W-1]}}, integ_q} + prod_sh[ACC_W+1:0]);
					end
					default: ;
				endcase
				if (step_q == ST_OUT) begin
					if (out_load) begin
						busy_q <= 1'b0;
						step_q <= ST_ERR;
					end
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !busy_q) begin
			sp_q <= setpoint;
			ms_q <= measured;
		end
		if (busy_q) begin
			case (step_q)
				ST_ERR: begin
					err_q  <= err_sat;
					diff_q <= {err_sat[DATA_W-1], err_sat} - {last_err_q[DATA_W-1], last_err_q};
				end
				ST_PROP: deriv_q <= sat_acc(prod_sh[ACC_W+1:0]);
				ST_IHI:  acc_q   <= prod_sh;
				ST_ILO:  acc_q   <= acc_q + prod;
				ST_DHI:  acc_q   <= acc_q + prod_sh;
				ST_DLO:  acc_q   <= acc_q + prod;
				ST_ACC:  acc_q   <= acc_q + prod_sh;
				default: ;
			endcase
		end
		if (out_load) begin
			if (acc_q > SUM_LIM_HI) begin
				drive_q   <= DRIVE_LIMIT;
				clamped_q <= 1'b1;
			end else if (acc_q < SUM_LIM_LO) begin
				drive_q   <= -DRIVE_LIMIT;
				clamped_q <= 1'b1;
			end else begin
				drive_q   <= acc_q[DRIVE_W-1:0];
				clamped_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/pidc_mul.sv */
// pidc_mul: shared signed 33x33 multiplier with a registered product.
// Depends on pidc_pkg.
module pidc_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [pidc_pkg::MUL_W-1:0]   a,
	input  logic signed [pidc_pkg::MUL_W-1:0]   b,
	output logic signed [pidc_pkg::PROD_W-1:0]  prod
);
	import pidc_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

/* rtl/pidc_check.sv */
// pidc_check: port-level assertions for the clamped PID controller, bound to
// the top level. Depends on pidc_pkg.
module pidc_check (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [pidc_pkg::DRIVE_W-1:0]  drive,
	input logic                                 clamped
);
	import pidc_pkg::*;

	// one word in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after an accepted word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clamped))
		else $error("result word changed while stalled");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive <= DRIVE_LIMIT && drive >= -DRIVE_LIMIT)
		else $error("drive beyond limit");

	a_clamp_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamped |-> drive == DRIVE_LIMIT || drive == -DRIVE_LIMIT)
		else $error("clamp flag set with drive inside limits");

endmodule

bind pid_controller_clamped_unit pidc_check u_pidc_check (.*);
